@@ rtl/text_console_writer_core_defines.svh @@
// ----------------------------------------------------------------------------
// text_console_writer_core_defines.svh
// Assertion macros shared by the console writer RTL. Each macro expects clk
// and arst_n to be in scope in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: word layouts,
// opcodes, character codes, configuration indexes and reset values.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Opcodes of the input word (code 3 does nothing)
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Control characters
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Light grey space on black, the cell value after reset
	localparam logic [15:0] BLANK_CELL = 16'h0720;

	// Tab stops every four columns
	localparam int TAB_STEP = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;
	localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'd7;
	localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'd0;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} in_word_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
	} out_word_t;

	// Memory strobes from the sequencer to the cell store
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_RDWAIT,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

@@ rtl/tcw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Character cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                clk,
	input  tcw_pkg::mem_ctl_t   ctl,
	input  logic [AW-1:0]       waddr,
	input  logic [15:0]         wdata,
	input  logic [AW-1:0]       raddr,
	output logic [15:0]         rdata
);
	import tcw_pkg::*;

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	// Write one cell
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one cell, data valid next cycle
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/tcw_agu.sv @@
// ----------------------------------------------------------------------------
// tcw_agu
// Shared address unit: cell address = row * COLUMNS + offset. Serves the
// cursor write, the cell read and the scroll source address.
// ----------------------------------------------------------------------------
module tcw_agu #(
	parameter int COLUMNS = 80,
	parameter int RW      = 5,
	parameter int AW      = 11
) (
	input  logic [RW-1:0] row,
	input  logic [AW-1:0] offset,
	output logic [AW-1:0] addr
);
	import tcw_pkg::*;

	logic [AW-1:0] row_base;

	// Scale the row by the line length, then add the offset
	assign row_base = AW'(row) * AW'(COLUMNS);
	assign addr     = row_base + offset;

endmodule

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: cursor, character decode, cell read, and the
// clear, scroll and reset sweeps over the cell store.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int CELLS   = 2000,
	parameter int AW      = 11,
	parameter int RW      = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcw_pkg::in_word_t   in_word,
	input  logic [7:0]          attr,
	input  logic                out_free,
	output logic                res_valid,
	output tcw_pkg::out_word_t  res,
	output tcw_pkg::mem_ctl_t   mem_ctl,
	output logic [AW-1:0]       waddr,
	output logic [15:0]         wdata,
	output logic [AW-1:0]       raddr,
	input  logic [15:0]         rdata,
	output logic [RW-1:0]       agu_row,
	output logic [AW-1:0]       agu_offset,
	input  logic [AW-1:0]       agu_addr
);
	import tcw_pkg::*;

	localparam int CW  = $clog2(COLUMNS);
	localparam int CNW = $clog2(COLUMNS + TAB_STEP);
	localparam int RNW = $clog2(ROWS + 1);
	localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS - 1);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);

	state_t        state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] ptr_s1;
	logic          copy_s1;
	logic [15:0]   fill_cell_q, fill_cell_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [15:0]   value_q, value_d;
	logic [7:0]    char_q;
	logic [4:0]    rrow_q;
	logic [6:0]    rcol_q;
	logic          rd_ok_q;
	logic          accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// State and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			copy_s1     <= 1'b0;
			fill_cell_q <= BLANK_CELL;
			col_q       <= '0;
			row_q       <= '0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			copy_s1     <= (state_q == ST_SCROLL);
			fill_cell_q <= fill_cell_d;
			col_q       <= col_d;
			row_q       <= row_d;
		end
	end

	// Payload registers of the item in flight
	always_ff @(posedge clk) begin
		ptr_s1  <= ptr_q;
		value_q <= value_d;
		if (accept) begin
			char_q  <= in_word.char_code;
			rrow_q  <= in_word.read_row;
			rcol_q  <= in_word.read_column;
			rd_ok_q <= (32'(in_word.read_row) < ROWS) && (32'(in_word.read_column) < COLUMNS);
		end
	end

	// Next state, cursor update and memory strobes
	always_comb begin
		logic [CNW-1:0] ncol;
		logic [RNW-1:0] nrow;
		logic [CW-1:0]  wcol;
		logic [7:0]     wchar;
		logic           put_we;

		state_d     = state_q;
		ptr_d       = ptr_q;
		fill_cell_d = fill_cell_q;
		col_d       = col_q;
		row_d       = row_q;
		value_d     = value_q;
		mem_ctl     = '0;
		waddr       = ptr_q;
		wdata       = fill_cell_q;
		raddr       = agu_addr;
		agu_row     = row_q;
		agu_offset  = '0;
		res_valid   = 1'b0;
		ncol        = CNW'(col_q);
		nrow        = RNW'(row_q);
		wcol        = col_q;
		wchar       = char_q;
		put_we      = 1'b0;

		case (state_q)
			ST_INIT: begin
				// Sweep the store with blank cells after reset
				mem_ctl.we = 1'b1;
				wdata      = BLANK_CELL;
				ptr_d      = ptr_q + 1'b1;
				if (ptr_q == LAST_CELL) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					value_d = '0;
					case (in_word.opcode)
						OP_PUT:   state_d = ST_PUT;
						OP_READ:  state_d = ST_READ;
						OP_CLEAR: begin
							ptr_d       = '0;
							fill_cell_d = {attr, CH_SPACE};
							col_d       = '0;
							row_d       = '0;
							state_d     = ST_FILL;
						end
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_PUT: begin
				// Decode the character and move the cursor
				case (char_q)
					CH_NL: begin
						ncol = '0;
						nrow = RNW'(row_q) + 1'b1;
					end
					CH_CR:  ncol = '0;
					CH_TAB: ncol = (CNW'(col_q) + CNW'(TAB_STEP)) & ~CNW'(TAB_STEP - 1);
					CH_BS: begin
						if (col_q != '0) begin
							wcol   = col_q - 1'b1;
							ncol   = CNW'(wcol);
							wchar  = CH_SPACE;
							put_we = 1'b1;
						end
					end
					default: begin
						put_we = 1'b1;
						ncol   = CNW'(col_q) + 1'b1;
					end
				endcase
				// Wrap at the end of the line
				if (ncol >= CNW'(COLUMNS)) begin
					ncol = '0;
					nrow = nrow + 1'b1;
				end
				agu_row    = row_q;
				agu_offset = AW'(wcol);
				mem_ctl.we = put_we;
				waddr      = agu_addr;
				wdata      = {attr, wchar};
				col_d      = CW'(ncol);
				// Scroll when the cursor leaves the last row
				if (nrow >= RNW'(ROWS)) begin
					row_d   = RW'(ROWS - 1);
					ptr_d   = '0;
					state_d = ST_SCROLL;
				end else begin
					row_d   = RW'(nrow);
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				agu_row    = RW'(rrow_q);
				agu_offset = AW'(rcol_q);
				mem_ctl.re = rd_ok_q;
				state_d    = ST_RDWAIT;
			end
			ST_RDWAIT: begin
				value_d = rd_ok_q ? rdata : '0;
				state_d = ST_DONE;
			end
			ST_SCROLL: begin
				// Read one line below, write back the cell read last cycle
				agu_row    = RW'(1);
				agu_offset = ptr_q;
				mem_ctl.re = 1'b1;
				mem_ctl.we = copy_s1;
				waddr      = ptr_s1;
				wdata      = rdata;
				ptr_d      = ptr_q + 1'b1;
				if (ptr_q == LAST_COPY) begin
					ptr_d       = BOTTOM_ROW;
					fill_cell_d = {attr, CH_SPACE};
					state_d     = ST_FILL;
				end
			end
			ST_FILL: begin
				mem_ctl.we = 1'b1;
				if (copy_s1) begin
					// Drain the last copied cell first
					waddr = ptr_s1;
					wdata = rdata;
				end else begin
					ptr_d = ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						ptr_d   = '0;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res.cell_value    = value_q;
	assign res.cursor_column = 7'(col_q);
	assign res.cursor_row    = 5'(row_q);

endmodule

@@ rtl/text_console_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: character cell store, cursor and colour registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_stall, in_data) carry one operation: put a
//   character, clear the screen, or read one cell. Each word gives exactly one
//   output word (out_valid/out_stall, out_data) with the read cell (0 for other
//   operations) and the cursor after the operation.
//   The colour registers are written through cfg_wr_en/cfg_index/cfg_wdata;
//   the user must write them only while idle; the block does not enforce it.
// Steps per word, from its accept to the earliest next accept with no stall;
// out_valid rises in the same cycle as that next accept:
//   put character: decode and write; with scroll, copy up and blank last row;
//   read one cell: address, then data; clear: blank every cell; no-op: result.
//   Scroll and clear move one cell per cycle through the store.
// Reset: the cursor goes to 0,0, colours to light grey on black, and a
//   clearing pass writes every cell blank, CELLS cells (2000 by default);
//   in_stall stays high until it ends. Configuration writes are taken anyway.
// Stall: the result sits in an output register; the next word is accepted
//   while it waits, and its own result holds until the register frees up.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_defines.svh"

module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  tcw_pkg::in_word_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tcw_pkg::out_word_t                 out_data,
	input  logic                               cfg_wr_en,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);

	logic [CFG_DATA_W-1:0] fg_q;
	logic [CFG_DATA_W-1:0] bg_q;
	logic                  in_ready;
	logic                  res_valid;
	out_word_t             res;
	logic                  out_free;
	logic                  out_valid_q;
	out_word_t             out_q;
	mem_ctl_t              mem_ctl;
	logic [AW-1:0]         waddr;
	logic [15:0]           wdata;
	logic [AW-1:0]         raddr;
	logic [15:0]           rdata;
	logic [RW-1:0]         agu_row;
	logic [AW-1:0]         agu_offset;
	logic [AW-1:0]         agu_addr;

	// Colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FOREGROUND: fg_q <= cfg_wdata;
				REG_BACKGROUND: bg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Output register: load a finished result when the slot frees up
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_stall  = !in_ready;

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.CELLS   (CELLS),
		.AW      (AW),
		.RW      (RW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_data),
		.attr       ({bg_q, fg_q}),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.mem_ctl    (mem_ctl),
		.waddr      (waddr),
		.wdata      (wdata),
		.raddr      (raddr),
		.rdata      (rdata),
		.agu_row    (agu_row),
		.agu_offset (agu_offset),
		.agu_addr   (agu_addr)
	);

	tcw_agu #(
		.COLUMNS (COLUMNS),
		.RW      (RW),
		.AW      (AW)
	) u_agu (
		.row    (agu_row),
		.offset (agu_offset),
		.addr   (agu_addr)
	);

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Busy in the cycle after taking a word
	`TCW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block ready right after accept")
	// Every store write lands inside the screen
	`TCW_ASSERT_NOW(a_write_in_range, mem_ctl.we, 32'(waddr) < CELLS, "cell write out of range")
	// A result handed to a free slot shows up on the output next cycle
	`TCW_ASSERT_NEXT(a_result_loaded, res_valid && out_free, out_valid, "result lost")

endmodule

@@ dv/text_console_writer_core_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer. A short table of directed
// words covers reset contents, out-of-range reads, the unused opcode and the
// control characters. Random bursts of text, newlines, reads and clears
// follow, under several color settings. Each result is checked field by
// field against the table or a cycle-free screen and cursor model kept here.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLS = DEF_COLUMNS;
	localparam int ROWS_N = DEF_ROWS;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int WORD_TARGET = 1950;
	localparam int PHASES = 5;
	localparam int IDLE_PCT = 6;
	localparam int SLOW_BUDGET = 130;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Screen model and cursor
	logic [15:0] screen_cells [ROWS_N*COLS];
	int unsigned col_pos;
	int unsigned row_pos;
	logic [3:0] fg_color;
	logic [3:0] bg_color;

	out_word_t pending_results [$];

	typedef struct {
		in_word_t word;
		bit typed;
		out_word_t want;
	} table_row_t;
	table_row_t directed_rows [$];

	int err_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int scroll_count = 0;
	int clear_count = 0;
	int read_count = 0;
	bit steady = 1'b0;

	text_console_writer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#16_000_000;
		$display("text_console_writer_core_tb: errors");
		$finish;
	end

	function automatic logic [15:0] colored(input logic [7:0] ch);
		return {bg_color, fg_color, ch};
	endfunction

	// Apply one word to the screen model and return its result word
	function automatic out_word_t console_step(input in_word_t w);
		out_word_t r;
		int unsigned i;
		r = '0;
		case (w.opcode)
			OP_PUT: begin
				if (w.char_code == CH_NL) begin
					col_pos = 0;
					row_pos++;
				end else if (w.char_code == CH_CR) begin
					col_pos = 0;
				end else if (w.char_code == CH_TAB) begin
					col_pos = (col_pos + TAB_STEP) & ~(TAB_STEP - 1);
				end else if (w.char_code == CH_BS) begin
					if (col_pos > 0) begin
						col_pos--;
						screen_cells[row_pos*COLS + col_pos] = colored(CH_SPACE);
					end
				end else begin
					screen_cells[row_pos*COLS + col_pos] = colored(w.char_code);
					col_pos++;
				end
				// wrap, then scroll one line
				if (col_pos >= COLS) begin
					col_pos = 0;
					row_pos++;
				end
				if (row_pos >= ROWS_N) begin
					for (i = 0; i < (ROWS_N-1)*COLS; i++)
						screen_cells[i] = screen_cells[i + COLS];
					for (i = (ROWS_N-1)*COLS; i < ROWS_N*COLS; i++)
						screen_cells[i] = colored(CH_SPACE);
					row_pos = ROWS_N - 1;
					scroll_count++;
				end
			end
			OP_CLEAR: begin
				for (i = 0; i < ROWS_N*COLS; i++)
					screen_cells[i] = colored(CH_SPACE);
				col_pos = 0;
				row_pos = 0;
				clear_count++;
			end
			OP_READ: begin
				if (w.read_row < ROWS_N && w.read_column < COLS)
					r.cell_value = screen_cells[w.read_row*COLS + w.read_column];
				read_count++;
			end
			default: ;
		endcase
		r.cursor_column = col_pos[6:0];
		r.cursor_row = row_pos[4:0];
		return r;
	endfunction

	// A word that would sweep the whole store (scroll or clear)
	function automatic bit would_be_slow(input in_word_t w);
		bit plain;
		plain = !(w.char_code inside {CH_BS, CH_TAB, CH_CR, CH_NL});
		if (w.opcode == OP_CLEAR)
			return 1'b1;
		if (w.opcode != OP_PUT || row_pos != ROWS_N - 1)
			return 1'b0;
		return w.char_code == CH_NL
			|| (w.char_code == CH_TAB && col_pos >= COLS - TAB_STEP)
			|| (plain && col_pos == COLS - 1);
	endfunction

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 19))
			0: return CH_BS;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_NL;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one word, hold it until taken, then log what it should produce
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t predicted;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = console_step(w);
		pending_results.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic offer(input logic [1:0] op, input logic [7:0] ch);
		in_word_t w;
		int pick;
		w.opcode = op;
		w.char_code = ch;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			w.read_row = 5'($urandom_range(0, 31));
			w.read_column = 7'($urandom_range(0, 127));
		end else begin
			w.read_row = (pick < 45) ? row_pos[4:0] : 5'($urandom_range(0, ROWS_N - 1));
			w.read_column = 7'($urandom_range(0, COLS - 1));
		end
		// keep the run short once enough full sweeps have been seen
		if (scroll_count + clear_count >= SLOW_BUDGET && would_be_slow(w))
			w.opcode = OP_READ;
		send_word(w, 1'b0, '0);
	endtask

	task automatic run_phase(input int n);
		int goal;
		int kind;
		int len;
		int k;
		goal = words_sent + n;
		while (words_sent < goal) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = $urandom_range(1, 100);
				for (k = 0; k < len; k++)
					offer(OP_PUT, text_char());
				if ($urandom_range(0, 1))
					offer(OP_PUT, CH_NL);
			end else if (kind < 65) begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					offer(OP_PUT, CH_NL);
			end else if (kind < 92) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					offer(OP_READ, 8'($urandom_range(0, 255)));
			end else if (kind < 94) begin
				offer(OP_CLEAR, 8'($urandom_range(0, 255)));
			end else begin
				offer(OP_NONE, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Write both colors while the block is idle
	task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
		in_valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FOREGROUND;
		cfg_wdata <= fg;
		@(posedge clk);
		cfg_index <= REG_BACKGROUND;
		cfg_wdata <= bg;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fg_color = fg;
		bg_color = bg;
	endtask

	task automatic add_row(input logic [1:0] op, input logic [7:0] ch, input logic [4:0] rr,
			input logic [6:0] rc, input bit typed, input logic [15:0] val,
			input logic [6:0] col, input logic [4:0] row);
		table_row_t t;
		t.word = '{opcode: op, char_code: ch, read_row: rr, read_column: rc};
		t.typed = typed;
		t.want = '{cell_value: val, cursor_column: col, cursor_row: row};
		directed_rows.push_back(t);
	endtask

	// Receiver: random stalls, one long hold-off, a quiet stretch
	initial begin : receiver
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				taken++;
			if (!held && taken >= HOLD_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Compare each taken result word with the oldest expectation
	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %h", out_data);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.cell_value !== want.cell_value) begin
					$error("cell_value: expected %h, got %h", want.cell_value,
						out_data.cell_value);
					err_count++;
				end
				if (out_data.cursor_column !== want.cursor_column) begin
					$error("cursor_column: expected %0d, got %0d", want.cursor_column,
						out_data.cursor_column);
					err_count++;
				end
				if (out_data.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row,
						out_data.cursor_row);
					err_count++;
				end
			end
			results_checked++;
		end
	end

	initial begin : stimulus
		int i;
		int per_phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		for (i = 0; i < ROWS_N*COLS; i++)
			screen_cells[i] = BLANK_CELL;
		col_pos = 0;
		row_pos = 0;
		fg_color = FG_RESET;
		bg_color = BG_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset contents, out-of-range reads, unused opcode, control characters
		add_row(OP_READ, 8'h00, 5'd0, 7'd0, 1, BLANK_CELL, 7'd0, 5'd0);
		add_row(OP_READ, 8'hFF, 5'd24, 7'd79, 1, BLANK_CELL, 7'd0, 5'd0);
		add_row(OP_READ, 8'h00, 5'd25, 7'd0, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_READ, 8'h00, 5'd31, 7'd127, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_READ, 8'h00, 5'd0, 7'd80, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_NONE, 8'hFF, 5'd31, 7'd127, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_PUT, CH_BS, 5'd0, 7'd0, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_PUT, 8'hFF, 5'd0, 7'd0, 1, 16'h0000, 7'd1, 5'd0);
		add_row(OP_PUT, 8'h00, 5'd31, 7'd127, 0, '0, '0, '0);
		add_row(OP_READ, 8'h00, 5'd0, 7'd0, 1, 16'h07FF, 7'd2, 5'd0);
		add_row(OP_READ, 8'h00, 5'd0, 7'd1, 1, 16'h0700, 7'd2, 5'd0);
		add_row(OP_PUT, CH_TAB, 5'd0, 7'd0, 1, 16'h0000, 7'd4, 5'd0);
		add_row(OP_PUT, CH_TAB, 5'd0, 7'd0, 1, 16'h0000, 7'd8, 5'd0);
		add_row(OP_PUT, 8'h5A, 5'd0, 7'd0, 0, '0, '0, '0);
		add_row(OP_PUT, CH_BS, 5'd0, 7'd0, 0, '0, '0, '0);
		add_row(OP_READ, 8'h00, 5'd0, 7'd8, 0, '0, '0, '0);
		add_row(OP_PUT, CH_CR, 5'd0, 7'd0, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_PUT, CH_NL, 5'd0, 7'd0, 1, 16'h0000, 7'd0, 5'd1);
		add_row(OP_PUT, 8'h80, 5'd0, 7'd0, 0, '0, '0, '0);
		add_row(OP_PUT, 8'h7F, 5'd0, 7'd0, 0, '0, '0, '0);
		add_row(OP_CLEAR, 8'h00, 5'd0, 7'd0, 1, 16'h0000, 7'd0, 5'd0);
		add_row(OP_READ, 8'h00, 5'd1, 7'd0, 1, BLANK_CELL, 7'd0, 5'd0);
		add_row(OP_PUT, CH_TAB, 5'd0, 7'd0, 0, '0, '0, '0);
		foreach (directed_rows[k])
			send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);

		// Random bursts under extreme and random colors
		per_phase = (WORD_TARGET - directed_rows.size()) / PHASES;
		for (i = 0; i < PHASES; i++) begin
			case (i)
				0: set_colors(4'hF, 4'hF);
				1: set_colors(4'h0, 4'h0);
				2: set_colors(4'hF, 4'h0);
				3: set_colors(4'h0, 4'hF);
				default: set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			endcase
			steady = (i == 2);
			run_phase(per_phase);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result words never arrived", pending_results.size());
			err_count++;
		end

		$display("Sent %0d words (%0d reads, %0d clears, %0d scrolls), checked %0d results.",
			words_sent, read_count, clear_count, scroll_count, results_checked);
		$display("Ran %0d color settings and one %0d-cycle receiver hold-off.",
			PHASES + 1, HOLD_CYCLES);
		if (err_count == 0)
			$display("text_console_writer_core_tb: clean");
		else
			$display("text_console_writer_core_tb: errors");
		$finish;
	end

endmodule

@@ text_console_writer_core.f @@
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_agu.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
dv/text_console_writer_core_tb.sv
